FILE: sv/evp_pkg.sv
// Shared constants, payload types and fixed-point helpers for the
// excluded-volume pair force block. No dependencies.
package evp_pkg;

    localparam int EVP_NUM_TYPES = 8;
    localparam int EVP_TYPE_W    = 3;
    localparam int EVP_DEL_W     = 24;
    localparam int EVP_CUT_W     = 20;
    localparam int EVP_ID_W      = 16;
    localparam int EVP_FAC_W     = 16;
    localparam int EVP_OUT_W     = 32;
    localparam int EVP_EXP_W     = 4;
    localparam logic [EVP_EXP_W-1:0] EVP_EXP_RESET = 4'd2;
    localparam int EVP_RES_NEAR  = 5;

    localparam int EVP_SQ_W      = 2 * EVP_DEL_W;
    localparam int EVP_RSQ_W     = 48;
    localparam int EVP_ROOT_W    = 25;
    localparam int EVP_COEF_W    = 24;
    localparam int EVP_PW_W      = 47;
    localparam int EVP_G_W       = EVP_PW_W + EVP_EXP_W;
    localparam int EVP_Q_W       = 31;
    localparam int EVP_QLO_W     = 16;
    localparam int EVP_REM_W     = EVP_ROOT_W;
    localparam int EVP_POW_STAGES = 15;
    localparam int EVP_MAG_W     = 48;
    localparam int EVP_CAP_W     = 63;
    localparam int EVP_CLAMP_W   = 84;
    localparam logic [EVP_CLAMP_W-1:0] EVP_SAT_CAP = EVP_CLAMP_W'(1) << 62;
    localparam logic [EVP_PW_W-1:0]    EVP_ONE     = EVP_PW_W'(1) << 16;

    typedef struct packed {
        logic [EVP_DEL_W-1:0] lam;
        logic [EVP_CUT_W-1:0] cut_s;
        logic [EVP_CUT_W-1:0] cut_l;
    } evp_coef_t;

    typedef struct packed {
        logic                           act;
        logic                           lam_neg;
        logic [2:0]                     d_neg;
        logic [2:0][EVP_DEL_W-1:0]      d_mag;
        logic [EVP_COEF_W-1:0]          c;
        logic [EVP_CUT_W-1:0]           rc;
    } evp_side_t;

    typedef struct packed {
        logic [2:0][EVP_OUT_W-1:0]      frc;
        logic [EVP_OUT_W-1:0]           energy;
        logic                           in_range;
    } evp_res_t;

    function automatic logic [EVP_CAP_W-1:0] evp_clamp(input logic [EVP_CLAMP_W-1:0] v);
        logic [EVP_CAP_W-1:0] res;
        if (v > EVP_SAT_CAP)
        begin
            res = EVP_SAT_CAP[EVP_CAP_W-1:0];
        end
        else
        begin
            res = v[EVP_CAP_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [EVP_OUT_W-1:0] evp_pack(input logic neg,
                                                      input logic [EVP_MAG_W-1:0] mag);
        logic [EVP_MAG_W-1:0] lim;
        logic [EVP_OUT_W-1:0] res;
        if (!neg)
        begin
            lim = (mag > EVP_MAG_W'(32'h7FFF_FFFF)) ? EVP_MAG_W'(32'h7FFF_FFFF) : mag;
            res = lim[EVP_OUT_W-1:0];
        end
        else
        begin
            lim = (mag > EVP_MAG_W'(32'h8000_0000)) ? EVP_MAG_W'(32'h8000_0000) : mag;
            res = EVP_OUT_W'(0) - lim[EVP_OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: sv/evp_chan_if.sv
// Valid/ready channels for pair items and result items.
// Depends on evp_pkg.
interface evp_in_if;
    import evp_pkg::*;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic signed [EVP_DEL_W-1:0] del_x;
    logic signed [EVP_DEL_W-1:0] del_y;
    logic signed [EVP_DEL_W-1:0] del_z;
    logic [EVP_ID_W-1:0]         res_i;
    logic [EVP_ID_W-1:0]         res_j;
    logic [EVP_ID_W-1:0]         mol_i;
    logic [EVP_ID_W-1:0]         mol_j;
    logic [EVP_TYPE_W-1:0]       type_i;
    logic [EVP_TYPE_W-1:0]       type_j;
    logic [EVP_FAC_W-1:0]        special_factor;

    modport source (output valid, action, del_x, del_y, del_z, res_i, res_j, mol_i, mol_j,
                    type_i, type_j, special_factor, input ready);
    modport sink   (input valid, action, del_x, del_y, del_z, res_i, res_j, mol_i, mol_j,
                    type_i, type_j, special_factor, output ready);
endinterface

interface evp_out_if;
    import evp_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [EVP_OUT_W-1:0] force_x;
    logic signed [EVP_OUT_W-1:0] force_y;
    logic signed [EVP_OUT_W-1:0] force_z;
    logic signed [EVP_OUT_W-1:0] pair_energy;
    logic                        in_range;

    modport source (output valid, force_x, force_y, force_z, pair_energy, in_range,
                    input ready);
    modport sink   (input valid, force_x, force_y, force_z, pair_energy, in_range,
                    output ready);
endinterface

FILE: sv/evp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module evp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/evp_coef_tab.sv
// Symmetric per-type-pair coefficient table: one RAM row per unordered
// type pair plus per-row valid bits. Depends on evp_pkg and evp_ram.
module evp_coef_tab
    import evp_pkg::*;
#(
    parameter int NUM_TYPES = EVP_NUM_TYPES
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic                  wr_en,
    input  logic [EVP_TYPE_W-1:0] type_i,
    input  logic [EVP_TYPE_W-1:0] type_j,
    input  evp_coef_t             wdata,
    output evp_coef_t             rdata
);

    localparam int DEPTH = NUM_TYPES * NUM_TYPES;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [EVP_TYPE_W-1:0] lo;
    logic [EVP_TYPE_W-1:0] hi;
    logic                  ok;
    logic [AW-1:0]         addr;
    logic [DEPTH-1:0]      vbit_reg;
    logic                  hit_reg;
    evp_coef_t             ram_q;

    assign lo   = (type_i < type_j) ? type_i : type_j;
    assign hi   = (type_i < type_j) ? type_j : type_i;
    assign ok   = (int'(type_i) < NUM_TYPES) && (int'(type_j) < NUM_TYPES);
    assign addr = AW'(int'(lo) * NUM_TYPES + int'(hi));

    evp_ram #(
        .WIDTH ($bits(evp_coef_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en & ok),
        .waddr (addr),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vbit_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en && ok)
            begin
                vbit_reg[addr] <= 1'b1;
            end
            if (rd_en)
            begin
                hit_reg <= ok && vbit_reg[addr];
            end
        end
    end

    assign rdata = hit_reg ? ram_q : '0;

endmodule

FILE: sv/evp_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with the
// item sideband carried alongside. Depends on evp_pkg.
module evp_sqrt_pipe
    import evp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  evp_side_t             in_side,
    input  logic [EVP_RSQ_W-1:0]  in_rsq,
    output logic                  out_vld,
    output evp_side_t             out_side,
    output logic [EVP_ROOT_W-1:0] out_r
);

    localparam int NST = EVP_ROOT_W;
    localparam int T_W = EVP_RSQ_W + 3;

    logic [NST-1:0]        vld_reg;
    evp_side_t             side_reg [NST];
    logic [EVP_RSQ_W-1:0]  rem_reg  [NST];
    logic [EVP_ROOT_W-1:0] root_reg [NST];
    logic [EVP_RSQ_W-1:0]  rem_next [NST];
    logic [EVP_ROOT_W-1:0] root_next [NST];

    for (genvar s = 0; s < NST; s++)
    begin : g_stage
        localparam int K = NST - 1 - s;
        logic [EVP_RSQ_W-1:0]  rem_in;
        logic [EVP_ROOT_W-1:0] root_in;
        logic [T_W-1:0]        trial;

        if (s == 0)
        begin : g_first
            assign rem_in  = in_rsq;
            assign root_in = '0;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
        end

        assign trial = (T_W'(root_in) << (K + 1)) + (T_W'(1) << (2 * K));

        always_comb
        begin
            if (T_W'(rem_in) >= trial)
            begin
                rem_next[s]  = rem_in - trial[EVP_RSQ_W-1:0];
                root_next[s] = root_in | (EVP_ROOT_W'(1) << K);
            end
            else
            begin
                rem_next[s]  = rem_in;
                root_next[s] = root_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int s = 0; s < NST; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
            for (int s = 1; s < NST; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_vld  = vld_reg[NST-1];
    assign out_side = side_reg[NST-1];
    assign out_r    = root_reg[NST-1];

endmodule

FILE: sv/evp_force_pipe.sv
// Range test, polynomial powers, per-axis del/r division and final force
// and energy products, one step per stage. Depends on evp_pkg.
module evp_force_pipe
    import evp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [EVP_EXP_W-1:0]  expo,
    input  logic                  in_vld,
    input  evp_side_t             in_side,
    input  logic [EVP_ROOT_W-1:0] in_r,
    output logic                  out_vld,
    output evp_res_t              out_res
);

    localparam int NST  = EVP_Q_W + 1;
    localparam int PL_W = EVP_G_W + EVP_QLO_W;
    localparam int PH_W = EVP_G_W + EVP_Q_W - EVP_QLO_W;
    localparam int PP_W = EVP_PW_W + EVP_CUT_W;
    localparam int EP_W = EVP_COEF_W + EVP_PW_W;
    localparam int FM_W = EVP_CAP_W - 30;

    typedef struct packed {
        evp_side_t                      side;
        logic                           rng;
        logic [EVP_ROOT_W-1:0]          r;
        logic [EVP_CUT_W-1:0]           m;
        logic [EVP_PW_W-1:0]            pw;
        logic [EVP_PW_W-1:0]            prev;
        logic [EVP_PW_W-1:0]            emag;
        logic [EVP_G_W-1:0]             g;
        logic [2:0][EVP_REM_W-1:0]      rem;
        logic [2:0][EVP_Q_W-1:0]        q;
    } fst_t;

    typedef struct packed {
        logic                           act;
        logic                           rng;
        logic                           rzero;
        logic                           lam_neg;
        logic [2:0]                     d_neg;
        logic [EVP_PW_W-1:0]            emag;
        logic [2:0][PL_W-1:0]           pl;
        logic [2:0][PH_W-1:0]           ph;
    } mst_t;

    logic [NST-1:0] vld_reg;
    fst_t           st_reg  [NST];
    fst_t           st_next [NST];
    logic           mv_reg;
    mst_t           m_reg;
    mst_t           m_next;
    logic           ov_reg;
    evp_res_t       res_reg;
    evp_res_t       res_next;

    always_comb
    begin
        st_next[0]      = '0;
        st_next[0].side = in_side;
        st_next[0].r    = in_r;
        st_next[0].rng  = !in_side.act && (in_r < EVP_ROOT_W'(in_side.rc));
        st_next[0].m    = in_side.rc - in_r[EVP_CUT_W-1:0];
        st_next[0].pw   = EVP_ONE;
        st_next[0].prev = EVP_ONE;
        for (int a = 0; a < 3; a++)
        begin
            st_next[0].rem[a] = EVP_REM_W'(in_side.d_mag[a] >> 1);
        end
    end

    for (genvar j = 0; j < EVP_Q_W; j++)
    begin : g_stage
        logic [2:0][EVP_REM_W:0] t;
        logic [PP_W-1:0]         pprod;
        logic [EP_W-1:0]         eprod;
        logic [EP_W-1:0]         gprod;
        logic [EVP_CAP_W-1:0]    pcl;
        logic [EVP_CAP_W-1:0]    ecl;
        logic [EVP_CAP_W-1:0]    gcl;

        assign pprod = st_reg[j].pw * st_reg[j].m;
        assign eprod = st_reg[j].side.c * st_reg[j].pw;
        assign gprod = st_reg[j].side.c * st_reg[j].prev;
        assign pcl   = evp_clamp(EVP_CLAMP_W'(pprod));
        assign ecl   = evp_clamp(EVP_CLAMP_W'(eprod));
        assign gcl   = evp_clamp(EVP_CLAMP_W'(gprod));

        always_comb
        begin
            st_next[j+1] = st_reg[j];
            for (int a = 0; a < 3; a++)
            begin
                t[a] = {st_reg[j].rem[a], (j == 0) ? st_reg[j].side.d_mag[a][0] : 1'b0};
                if (t[a] >= {1'b0, st_reg[j].r})
                begin
                    st_next[j+1].rem[a] = EVP_REM_W'(t[a] - {1'b0, st_reg[j].r});
                    st_next[j+1].q[a][EVP_Q_W-1-j] = 1'b1;
                end
                else
                begin
                    st_next[j+1].rem[a] = t[a][EVP_REM_W-1:0];
                end
            end
            if (j < EVP_POW_STAGES)
            begin
                if (EVP_EXP_W'(j) < expo)
                begin
                    st_next[j+1].prev = st_reg[j].pw;
                    st_next[j+1].pw   = pcl[EVP_CAP_W-1:16];
                end
            end
            if (j == EVP_POW_STAGES)
            begin
                st_next[j+1].emag = ecl[EVP_CAP_W-1:16];
                st_next[j+1].g    = EVP_G_W'(gcl[EVP_CAP_W-1:16]);
            end
            if (j == EVP_POW_STAGES + 1)
            begin
                st_next[j+1].g = EVP_G_W'(st_reg[j].g[EVP_PW_W-1:0] * expo);
            end
        end
    end

    always_comb
    begin
        m_next.act     = st_reg[NST-1].side.act;
        m_next.rng     = st_reg[NST-1].rng;
        m_next.rzero   = (st_reg[NST-1].r == '0);
        m_next.lam_neg = st_reg[NST-1].side.lam_neg;
        m_next.d_neg   = st_reg[NST-1].side.d_neg;
        m_next.emag    = st_reg[NST-1].emag;
        for (int a = 0; a < 3; a++)
        begin
            m_next.pl[a] = st_reg[NST-1].g * st_reg[NST-1].q[a][EVP_QLO_W-1:0];
            m_next.ph[a] = st_reg[NST-1].g * st_reg[NST-1].q[a][EVP_Q_W-1:EVP_QLO_W];
        end
    end

    always_comb
    begin
        logic [EVP_CLAMP_W-1:0] sum;
        logic [EVP_CAP_W-1:0]   fcl;
        sum      = '0;
        fcl      = '0;
        res_next = '0;
        if (!m_reg.act && m_reg.rng)
        begin
            res_next.in_range = 1'b1;
            res_next.energy   = evp_pack(m_reg.lam_neg, EVP_MAG_W'(m_reg.emag));
            for (int a = 0; a < 3; a++)
            begin
                sum = (EVP_CLAMP_W'(m_reg.ph[a]) << EVP_QLO_W) + EVP_CLAMP_W'(m_reg.pl[a]);
                fcl = evp_clamp(sum);
                if (!m_reg.rzero && (expo != '0))
                begin
                    res_next.frc[a] = evp_pack(m_reg.lam_neg ^ m_reg.d_neg[a],
                                               EVP_MAG_W'(fcl[EVP_CAP_W-1:EVP_CAP_W-FM_W]));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            mv_reg  <= 1'b0;
            ov_reg  <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], in_vld};
            mv_reg  <= vld_reg[NST-1];
            ov_reg  <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NST; s++)
            begin
                st_reg[s] <= st_next[s];
            end
            m_reg   <= m_next;
            res_reg <= res_next;
        end
    end

    assign out_vld = ov_reg;
    assign out_res = res_reg;

endmodule

FILE: sv/excluded_volume_pair_force.sv
// Top level of the excluded-volume pair force pipeline.
// Depends on evp_pkg, evp_chan_if, evp_coef_tab, evp_sqrt_pipe, evp_force_pipe.
//
// Usage:
//   pairs   - one item per pair: action 0 computes forces and energy for a
//             displacement, action 1 loads lambda and both cutoffs for a
//             type pair (stored symmetrically).
//   results - one item per pair item, in order. Write items give all zero.
//   cfg_we / cfg_wdata - load the exponent p; write only while idle.
// Throughput: one pair per cycle while the pipeline advances, which
//   runs through the 25-stage square root and the 31-stage quotient
//   pipeline that also hosts the fifteen power multiplies.
// Reset: exponent returns to 2, all coefficient rows read as zero (one
//   valid bit per row), pipeline and output buffer empty.
// Stall: a two-entry output buffer holds finished items; the whole
//   pipeline advances while the buffer has room or results.ready is high,
//   and pairs.ready follows that advance enable.
module excluded_volume_pair_force
    import evp_pkg::*;
#(
    parameter int NUM_TYPES = EVP_NUM_TYPES
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [EVP_EXP_W-1:0] cfg_wdata,
    evp_in_if.sink               pairs,
    evp_out_if.source            results
);

    typedef struct packed {
        logic                      act;
        logic                      near;
        logic [2:0]                d_neg;
        logic [2:0][EVP_DEL_W-1:0] d_mag;
        logic [EVP_FAC_W-1:0]      f;
    } s1_t;

    localparam int CP_W = EVP_DEL_W + EVP_FAC_W;

    logic [EVP_EXP_W-1:0]      exp_reg;
    logic                      en;
    logic                      accept;
    logic [EVP_ID_W-1:0]       res_diff;
    logic [2:0][EVP_DEL_W-1:0] dels;

    logic                      s1_vld_reg;
    s1_t                       s1_reg;
    s1_t                       s1_next;
    evp_coef_t                 tab_q;
    evp_coef_t                 tab_wdata;
    logic [EVP_DEL_W-1:0]      lam_abs;
    logic [CP_W-1:0]           cprod;

    logic                      s2_vld_reg;
    evp_side_t                 s2_side_reg;
    evp_side_t                 s2_side_next;
    logic [2:0][EVP_SQ_W-1:0]  s2_sq_reg;
    logic [2:0][EVP_SQ_W-1:0]  s2_sq_next;
    logic [EVP_SQ_W+1:0]       rsq_sum;

    logic                      sq_vld;
    evp_side_t                 sq_side;
    logic [EVP_ROOT_W-1:0]     sq_r;
    logic                      f_vld;
    evp_res_t                  f_res;

    evp_res_t                  fifo_reg [2];
    logic [1:0]                cnt_reg;
    logic [1:0]                cnt_next;
    logic                      wptr_reg;
    logic                      rptr_reg;
    logic                      push;
    logic                      pop;
    evp_res_t                  head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_reg <= EVP_EXP_RESET;
        end
        else if (cfg_we)
        begin
            exp_reg <= cfg_wdata;
        end
    end

    assign en          = (cnt_reg != 2'd2) || results.ready;
    assign pairs.ready = en;
    assign accept      = pairs.valid && en;

    assign dels     = {pairs.del_z, pairs.del_y, pairs.del_x};
    assign res_diff = (pairs.res_i >= pairs.res_j) ? (pairs.res_i - pairs.res_j)
                                                   : (pairs.res_j - pairs.res_i);

    always_comb
    begin
        s1_next.act  = pairs.action;
        s1_next.near = (res_diff < EVP_ID_W'(EVP_RES_NEAR)) && (pairs.mol_i == pairs.mol_j);
        s1_next.f    = pairs.special_factor;
        for (int a = 0; a < 3; a++)
        begin
            s1_next.d_neg[a] = dels[a][EVP_DEL_W-1];
            s1_next.d_mag[a] = dels[a][EVP_DEL_W-1] ? (EVP_DEL_W'(0) - dels[a]) : dels[a];
        end
    end

    assign tab_wdata.lam   = pairs.del_x;
    assign tab_wdata.cut_s = pairs.del_y[EVP_CUT_W-1:0];
    assign tab_wdata.cut_l = pairs.del_z[EVP_CUT_W-1:0];

    evp_coef_tab #(
        .NUM_TYPES (NUM_TYPES)
    ) u_tab (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (accept),
        .wr_en  (accept && pairs.action),
        .type_i (pairs.type_i),
        .type_j (pairs.type_j),
        .wdata  (tab_wdata),
        .rdata  (tab_q)
    );

    assign lam_abs = tab_q.lam[EVP_DEL_W-1] ? (EVP_DEL_W'(0) - tab_q.lam) : tab_q.lam;
    assign cprod   = lam_abs * s1_reg.f;

    always_comb
    begin
        s2_side_next.act     = s1_reg.act;
        s2_side_next.lam_neg = tab_q.lam[EVP_DEL_W-1];
        s2_side_next.d_neg   = s1_reg.d_neg;
        s2_side_next.d_mag   = s1_reg.d_mag;
        s2_side_next.c       = cprod[EVP_COEF_W+14:15];
        s2_side_next.rc      = s1_reg.near ? tab_q.cut_s : tab_q.cut_l;
        for (int a = 0; a < 3; a++)
        begin
            s2_sq_next[a] = s1_reg.d_mag[a] * s1_reg.d_mag[a];
        end
    end

    assign rsq_sum = (EVP_SQ_W+2)'(s2_sq_reg[0]) + (EVP_SQ_W+2)'(s2_sq_reg[1])
                   + (EVP_SQ_W+2)'(s2_sq_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= pairs.valid;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg      <= s1_next;
            s2_side_reg <= s2_side_next;
            s2_sq_reg   <= s2_sq_next;
        end
    end

    evp_sqrt_pipe u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s2_vld_reg),
        .in_side  (s2_side_reg),
        .in_rsq   (rsq_sum[EVP_RSQ_W-1:0]),
        .out_vld  (sq_vld),
        .out_side (sq_side),
        .out_r    (sq_r)
    );

    evp_force_pipe u_force (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .expo    (exp_reg),
        .in_vld  (sq_vld),
        .in_side (sq_side),
        .in_r    (sq_r),
        .out_vld (f_vld),
        .out_res (f_res)
    );

    assign push = en && f_vld;
    assign pop  = results.valid && results.ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= f_res;
        end
    end

    assign head                = fifo_reg[rptr_reg];
    assign results.valid       = (cnt_reg != 2'd0);
    assign results.force_x     = head.frc[0];
    assign results.force_y     = head.frc[1];
    assign results.force_z     = head.frc[2];
    assign results.pair_energy = head.energy;
    assign results.in_range    = head.in_range;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && (cnt_reg == 2'd2)))
        else $error("push into full output buffer");

    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != 2'd2) |-> pairs.ready)
        else $error("input stalled while output buffer has room");

    a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.in_range) |->
        (results.force_x == '0 && results.force_y == '0 &&
         results.force_z == '0 && results.pair_energy == '0))
        else $error("out-of-range item carries nonzero force or energy");
`endif

endmodule

FILE: verif/excluded_volume_pair_force_tb.sv
// Testbench for excluded_volume_pair_force: random pair and table-write items
// are checked against a fixed-point force predictor held in a scoreboard class.
// Depends on evp_pkg, evp_chan_if and the RTL of the block.
module excluded_volume_pair_force_tb;
    import evp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_PAIR  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;
    localparam int   LATENCY   = 61;

    typedef struct packed {
        logic        act;
        logic [23:0] dx;
        logic [23:0] dy;
        logic [23:0] dz;
        logic [15:0] ri;
        logic [15:0] rj;
        logic [15:0] mi;
        logic [15:0] mj;
        logic [2:0]  ti;
        logic [2:0]  tj;
        logic [15:0] fac;
    } pair_item_t;

    typedef struct packed {
        logic [31:0] fx;
        logic [31:0] fy;
        logic [31:0] fz;
        logic [31:0] en;
        logic        hit;
    } force_item_t;

    class force_scoreboard;
        logic [3:0]  power;
        logic [23:0] lam_tab [64];
        logic [19:0] cs_tab [64];
        logic [19:0] cl_tab [64];
        force_item_t pending [$];
        int          errors;

        function new();
            power = EVP_EXP_RESET;
            errors = 0;
            for (int k = 0; k < 64; k++)
            begin
                lam_tab[k] = '0;
                cs_tab[k] = '0;
                cl_tab[k] = '0;
            end
        endfunction

        function logic [63:0] mulcap(logic [63:0] a, logic [63:0] b);
            logic [127:0] pr;
            pr = a * b;
            return (pr > (128'd1 << 62)) ? (64'd1 << 62) : pr[63:0];
        endfunction

        function logic [63:0] root(logic [63:0] v);
            logic [63:0] res;
            logic [63:0] bt;
            res = 0;
            bt = 64'd1 << 48;
            while (bt > v)
                bt >>= 2;
            while (bt != 0)
            begin
                if (v >= res + bt)
                begin
                    v -= res + bt;
                    res = (res >> 1) + bt;
                end
                else
                    res >>= 1;
                bt >>= 2;
            end
            return res;
        endfunction

        function logic [31:0] sat(logic neg, logic [63:0] mag);
            if (!neg)
                return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            return 32'd0 - mag[31:0];
        endfunction

        function void note_pair(pair_item_t it);
            force_item_t e;
            logic signed [23:0] d [3];
            logic [63:0] dm [3];
            logic [63:0] rsq, r, m, c, pw, prv, g, q;
            logic signed [23:0] lam;
            logic [19:0] rc;
            int a, b, dr;
            e = '0;
            a = it.ti * 8 + it.tj;
            b = it.tj * 8 + it.ti;
            if (it.act == ACT_WRITE)
            begin
                lam_tab[a] = it.dx; lam_tab[b] = it.dx;
                cs_tab[a] = it.dy[19:0]; cs_tab[b] = it.dy[19:0];
                cl_tab[a] = it.dz[19:0]; cl_tab[b] = it.dz[19:0];
                pending.push_back(e);
                return;
            end
            d[0] = it.dx; d[1] = it.dy; d[2] = it.dz;
            rsq = 0;
            for (int k = 0; k < 3; k++)
            begin
                dm[k] = d[k] < 0 ? 64'(-64'(d[k])) : 64'(d[k]);
                rsq += dm[k] * dm[k];
            end
            r = root(rsq);
            dr = int'(it.ri) - int'(it.rj);
            lam = lam_tab[a];
            rc = (dr > -EVP_RES_NEAR && dr < EVP_RES_NEAR && it.mi == it.mj) ?
                 cs_tab[a] : cl_tab[a];
            if (r < 64'(rc))
            begin
                e.hit = 1'b1;
                m = 64'(rc) - r;
                c = ((lam < 0 ? 64'(-64'(lam)) : 64'(lam)) * 64'(it.fac)) >> 15;
                pw = 64'd1 << 16;
                prv = pw;
                for (int k = 0; k < power; k++)
                begin
                    prv = pw;
                    pw = mulcap(pw, m) >> 16;
                end
                e.en = sat(lam < 0, mulcap(c, pw) >> 16);
                if (r != 0 && power != 0)
                begin
                    g = (mulcap(c, prv) >> 16) * power;
                    for (int k = 0; k < 3; k++)
                    begin
                        q = (dm[k] << 30) / r;
                        if (k == 0) e.fx = sat((lam < 0) != (d[k] < 0), mulcap(g, q) >> 30);
                        if (k == 1) e.fy = sat((lam < 0) != (d[k] < 0), mulcap(g, q) >> 30);
                        if (k == 2) e.fz = sat((lam < 0) != (d[k] < 0), mulcap(g, q) >> 30);
                    end
                end
            end
            pending.push_back(e);
        endfunction

        function void check_force(force_item_t got);
            force_item_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result %h", $time, got);
                return;
            end
            e = pending.pop_front();
            if (got.fx !== e.fx)
                $display("%0t: force_x expected %h actual %h", $time, e.fx, got.fx);
            if (got.fy !== e.fy)
                $display("%0t: force_y expected %h actual %h", $time, e.fy, got.fy);
            if (got.fz !== e.fz)
                $display("%0t: force_z expected %h actual %h", $time, e.fz, got.fz);
            if (got.en !== e.en)
                $display("%0t: pair_energy expected %h actual %h", $time, e.en, got.en);
            if (got.hit !== e.hit)
                $display("%0t: in_range expected %b actual %b", $time, e.hit, got.hit);
            if (got !== e)
                errors++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [EVP_EXP_W-1:0] cfg_wdata;
    evp_in_if  pairs ();
    evp_out_if results ();
    force_scoreboard sb;
    bit stall_on;

    excluded_volume_pair_force u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .pairs(pairs.sink), .results(results.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pairs.valid && pairs.ready)
                sb.note_pair({pairs.action, pairs.del_x, pairs.del_y, pairs.del_z,
                              pairs.res_i, pairs.res_j, pairs.mol_i, pairs.mol_j,
                              pairs.type_i, pairs.type_j, pairs.special_factor});
            if (results.valid && results.ready)
                sb.check_force({results.force_x, results.force_y, results.force_z,
                                results.pair_energy, results.in_range});
            case ($urandom_range(0, 15))
                0: stall_on <= 1'b1;
                1, 2: stall_on <= 1'b0;
                default: ;
            endcase
            results.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    function automatic pair_item_t rand_pair(bit table_write);
        pair_item_t it;
        int mode;
        it.act = table_write ? ACT_WRITE : ACT_PAIR;
        mode = $urandom_range(0, 9);
        it.dx = (mode < 7) ? 24'($signed($urandom_range(0, 393216)) - 196608) : 24'($urandom);
        it.dy = (mode < 7) ? 24'($signed($urandom_range(0, 393216)) - 196608) : 24'($urandom);
        it.dz = (mode < 7) ? 24'($signed($urandom_range(0, 393216)) - 196608) : 24'($urandom);
        it.ri = 16'($urandom);
        it.rj = ($urandom_range(0, 1)) ? 16'(it.ri + $urandom_range(0, 8) - 4) : 16'($urandom);
        it.mi = 16'($urandom);
        it.mj = ($urandom_range(0, 2) != 0) ? it.mi : 16'($urandom);
        it.ti = 3'($urandom);
        it.tj = 3'($urandom);
        it.fac = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 32768)) :
                 16'($urandom_range(16384, 32768));
        if (table_write)
        begin
            it.dx = 24'($urandom);
            it.dy = ($urandom_range(0, 4) == 0) ? 24'($urandom) :
                    24'($urandom_range(0, 262144));
            it.dz = ($urandom_range(0, 4) == 0) ? 24'($urandom) :
                    24'($urandom_range(0, 393216));
        end
        return it;
    endfunction

    task automatic send_pair(pair_item_t it);
        pairs.valid          <= 1'b1;
        pairs.action         <= it.act;
        pairs.del_x          <= it.dx;
        pairs.del_y          <= it.dy;
        pairs.del_z          <= it.dz;
        pairs.res_i          <= it.ri;
        pairs.res_j          <= it.rj;
        pairs.mol_i          <= it.mi;
        pairs.mol_j          <= it.mj;
        pairs.type_i         <= it.ti;
        pairs.type_j         <= it.tj;
        pairs.special_factor <= it.fac;
        do
            @(posedge clk);
        while (!pairs.ready);
    endtask

    task automatic pause_sender(int cycles);
        pairs.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        pause_sender(1);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic set_power(logic [3:0] p);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= p;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.power = p;
        @(posedge clk);
    endtask

    task automatic send_burst(int count, int write_pct);
        int left;
        left = count;
        while (left > 0)
        begin
            for (int k = $urandom_range(1, 20); k > 0 && left > 0; k--)
            begin
                send_pair(rand_pair($urandom_range(0, 99) < write_pct));
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        pair_item_t it;
        logic [3:0] powers [6] = '{4'd1, 4'd12, 4'd0, 4'd15, 4'd3, 4'd7};
        sb = new();
        stall_on = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pairs.valid = 1'b0;
        pairs.action = ACT_PAIR;
        pairs.del_x = '0;
        pairs.del_y = '0;
        pairs.del_z = '0;
        pairs.res_i = '0;
        pairs.res_j = '0;
        pairs.mol_i = '0;
        pairs.mol_j = '0;
        pairs.type_i = '0;
        pairs.type_j = '0;
        pairs.special_factor = '0;
        results.ready = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        it = rand_pair(0);
        it.dx = 24'd1000; it.dy = 0; it.dz = 0;
        send_pair(it);
        it = rand_pair(1);
        it.ti = 3'd0; it.tj = 3'd7; it.dx = 24'h7FFFFF; it.dy = 24'hFFFFF; it.dz = 24'hFFFFF;
        send_pair(it);
        it = rand_pair(1);
        it.ti = 3'd2; it.tj = 3'd3; it.dx = 24'h800000; it.dy = 24'h30000; it.dz = 24'h50000;
        send_pair(it);
        it = rand_pair(0);
        it.ti = 3'd7; it.tj = 3'd0; it.dx = 0; it.dy = 0; it.dz = 0; it.fac = 16'd32768;
        send_pair(it);
        it.dx = 24'h7FFFFF; it.dy = 24'h800000; it.dz = 24'h7FFFFF;
        send_pair(it);
        it.dx = 24'h000100; it.dy = 24'hFFFF00; it.dz = 24'h000001; it.fac = 16'hFFFF;
        send_pair(it);
        for (int k = 0; k < 6; k++)
        begin
            it = rand_pair(0);
            it.ti = 3'd3; it.tj = 3'd2;
            it.ri = 16'd100; it.rj = 16'(96 + 2 * k); it.mi = 16'd5;
            it.mj = (k == 5) ? 16'd6 : 16'd5;
            it.dx = 24'h01_0000; it.dy = 24'hFF_8000; it.dz = 0;
            send_pair(it);
        end
        it.ri = 16'hFFFF; it.rj = 16'd0; it.mi = 16'hFFFF; it.mj = 16'hFFFF;
        send_pair(it);

        send_burst(30, 60);
        for (int ph = 0; ph < 6; ph++)
        begin
            set_power(powers[ph]);
            send_burst(85, 10);
        end
        drain();

        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
